### sv/disc_image_track_entry_decoder_defines.svh
// Assertion macros for the disc image track entry decoder.
`ifndef DISC_IMAGE_TRACK_ENTRY_DECODER_DEFINES_SVH
`define DISC_IMAGE_TRACK_ENTRY_DECODER_DEFINES_SVH
`ifndef SYNTHESIS
`define DITD_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
`define DITD_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define DITD_ASSERT_IMP(label, clk, rst, ante, cons, msg)
`define DITD_ASSERT_NXT(label, clk, rst, ante, cons, msg)
`endif
`endif

### sv/ditd_pkg.sv
// Types, codes and mode table shared by the track entry decoder files.
package ditd_pkg;

   localparam logic [1:0] STATUS_OK   = 2'd0;
   localparam logic [1:0] STATUS_SKIP = 2'd1;
   localparam logic [1:0] STATUS_ERR  = 2'd2;

   localparam logic [1:0] KIND_M1    = 2'd0;
   localparam logic [1:0] KIND_M2    = 2'd1;
   localparam logic [1:0] KIND_AUDIO = 2'd2;

   localparam logic [31:0] MODE_M1_2048   = 32'h00;
   localparam logic [31:0] MODE_M2_2048   = 32'h02;
   localparam logic [31:0] MODE_M2_2336_A = 32'h03;
   localparam logic [31:0] MODE_M2_2336_B = 32'h06;
   localparam logic [31:0] MODE_M2_2336_C = 32'h20;
   localparam logic [31:0] MODE_M1_2352   = 32'h05;
   localparam logic [31:0] MODE_AUDIO     = 32'h07;

   localparam logic [15:0] SIZE_2048 = 16'd2048;
   localparam logic [15:0] SIZE_2336 = 16'd2336;
   localparam logic [15:0] SIZE_2352 = 16'd2352;
   localparam logic [15:0] SIZE_2448 = 16'd2448;

   localparam logic [4:0] OFF_NONE = 5'd0;
   localparam logic [4:0] OFF_8    = 5'd8;
   localparam logic [4:0] OFF_16   = 5'd16;
   localparam logic [4:0] OFF_24   = 5'd24;

   localparam logic [63:0] GAP_SECTORS = 64'd150;
   localparam logic [31:0] GAP_PER_ENTRY = 32'd150;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DECODE,
      ST_DIV_LSN,
      ST_REBASE,
      ST_DIV_COUNT,
      ST_EMIT
   } state_type;

   typedef struct packed {
      logic        known;
      logic [1:0]  kind;
      logic [15:0] size;
      logic [4:0]  off;
   } mode_info_type;

   typedef struct packed {
      logic        start;
      logic [63:0] dividend;
      logic [15:0] divisor;
   } div_req_type;

   typedef struct packed {
      logic        done;
      logic [63:0] quotient;
   } div_rsp_type;

   function automatic mode_info_type map_mode(input logic [31:0] code);
      mode_info_type m;
      m = '{known: 1'b1, kind: KIND_M1, size: SIZE_2048, off: OFF_NONE};
      unique case (code) inside
         MODE_M1_2048: m = '{known: 1'b1, kind: KIND_M1, size: SIZE_2048, off: OFF_NONE};
         MODE_M2_2048: m = '{known: 1'b1, kind: KIND_M2, size: SIZE_2048, off: OFF_NONE};
         MODE_M2_2336_A, MODE_M2_2336_B, MODE_M2_2336_C:
            m = '{known: 1'b1, kind: KIND_M2, size: SIZE_2336, off: OFF_8};
         MODE_M1_2352: m = '{known: 1'b1, kind: KIND_M1, size: SIZE_2352, off: OFF_16};
         MODE_AUDIO:   m = '{known: 1'b1, kind: KIND_AUDIO, size: SIZE_2352, off: OFF_NONE};
         default:      m = '{known: 1'b0, kind: KIND_M1, size: '0, off: OFF_NONE};
      endcase
      return m;
   endfunction

   function automatic logic [4:0] size_offset(input logic [15:0] size, input logic [1:0] kind);
      logic [4:0] off;
      off = OFF_NONE;
      case (size) inside
         SIZE_2336: off = OFF_8;
         SIZE_2352, SIZE_2448: begin
            if (kind == KIND_M2) begin
               off = OFF_24;
            end else if (kind == KIND_M1) begin
               off = OFF_16;
            end else begin
               off = OFF_NONE;
            end
         end
         default: off = OFF_NONE;
      endcase
      return off;
   endfunction

endpackage

### sv/ditd_divider.sv
// Radix-2 restoring divider, 64-bit dividend by 16-bit divisor, one bit per cycle.
module ditd_divider
   import ditd_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  div_req_type div_req,
   output div_rsp_type div_rsp
);

   logic        busy_ff, busy_in;
   logic        done_ff, done_in;
   logic [5:0]  cnt_ff, cnt_in;
   logic [15:0] rem_ff, rem_in;
   logic [63:0] quot_ff, quot_in;
   logic [15:0] divisor_ff, divisor_in;
   logic [16:0] trial;
   logic [16:0] diff;

   assign trial = {rem_ff, quot_ff[63]};
   assign diff  = trial - {1'b0, divisor_ff};

   always_comb begin
      busy_in    = busy_ff;
      done_in    = 1'b0;
      cnt_in     = cnt_ff;
      rem_in     = rem_ff;
      quot_in    = quot_ff;
      divisor_in = divisor_ff;
      if (div_req.start) begin
         busy_in    = 1'b1;
         cnt_in     = '0;
         rem_in     = '0;
         quot_in    = div_req.dividend;
         divisor_in = div_req.divisor;
      end else if (busy_ff) begin
         if (trial >= {1'b0, divisor_ff}) begin
            rem_in  = diff[15:0];
            quot_in = {quot_ff[62:0], 1'b1};
         end else begin
            rem_in  = trial[15:0];
            quot_in = {quot_ff[62:0], 1'b0};
         end
         cnt_in = cnt_ff + 6'd1;
         if (cnt_ff == '1) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff     <= rem_in;
      quot_ff    <= quot_in;
      divisor_ff <= divisor_in;
   end

   assign div_rsp.done     = done_ff;
   assign div_rsp.quotient = quot_ff;

endmodule

### sv/disc_image_track_entry_decoder.sv
// Top level of the disc image track entry decoder.
//
// Takes one track entry per req_ transaction and gives one result per rsp_
// transaction: a track record, a skip status or an unsupported-mode error.
// Both channels use valid/ready; req_ready is high only while the sequencer
// is idle, so one entry is in work at a time.
// An error or an early skip goes straight from decode to the result; the
// other entries wait on the shared bit-serial divider, which works out one
// quotient at a time: a disc-at-once entry needs two quotients (start
// address and sector count), a track-at-once entry one, and a disc-at-once
// entry skipped for a negative address stops after the first.
// The result sits in an output register, so the next entry is taken while
// a finished result waits; a stalled receiver holds the sequencer only
// when a second result is ready to be written.
// Synchronous reset clears the sequencer, the output valid and the chunk
// rebase state; entry number 0 clears the rebase state as well.
`include "disc_image_track_entry_decoder_defines.svh"
module disc_image_track_entry_decoder
   import ditd_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_layout_kind,
   input  logic [6:0]  req_entry_number,
   input  logic [31:0] req_mode_code,
   input  logic [15:0] req_recorded_sector_size,
   input  logic [63:0] req_first_offset,
   input  logic [63:0] req_second_value,
   input  logic [31:0] req_recorded_lsn,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [1:0]  rsp_status,
   output logic [31:0] rsp_start_sector,
   output logic [31:0] rsp_sector_count,
   output logic [15:0] rsp_sector_bytes,
   output logic [4:0]  rsp_payload_offset,
   output logic [1:0]  rsp_track_kind,
   output logic [63:0] rsp_source_offset
);

   state_type   state_ff, state_in;
   logic        layout_ff, layout_in;
   logic [6:0]  entry_ff, entry_in;
   logic [31:0] code_ff, code_in;
   logic [15:0] rec_size_ff, rec_size_in;
   logic [63:0] first_ff, first_in;
   logic [63:0] second_ff, second_in;
   logic [31:0] rec_lsn_ff, rec_lsn_in;
   logic [15:0] size_ff, size_in;
   logic [4:0]  off_ff, off_in;
   logic [1:0]  kind_ff, kind_in;
   logic [1:0]  status_ff, status_in;
   logic [31:0] start_ff, start_in;
   logic [31:0] count_ff, count_in;
   logic [63:0] lsn_ff, lsn_in;
   logic [63:0] rebase_amount_ff, rebase_amount_in;
   logic        rebase_valid_ff, rebase_valid_in;
   logic        rsp_valid_ff, rsp_valid_in;
   logic [1:0]  rsp_status_ff;
   logic [31:0] rsp_start_ff;
   logic [31:0] rsp_count_ff;
   logic [15:0] rsp_bytes_ff;
   logic [4:0]  rsp_off_ff;
   logic [1:0]  rsp_kind_ff;
   logic [63:0] rsp_source_ff;

   mode_info_type mode;
   logic [15:0]   eff_size;
   logic [4:0]    eff_off;
   logic [1:0]    dec_status;
   logic          dec_pass;
   logic [31:0]   tao_start;
   logic [63:0]   rebased;
   logic          rebase_neg;
   logic          rsp_load;
   div_req_type   div_req;
   div_rsp_type   div_rsp;

   ditd_divider u_divider (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   // entry decode
   always_comb begin
      mode     = map_mode(code_ff);
      eff_size = mode.size;
      eff_off  = mode.off;
      if (!layout_ff && (rec_size_ff != '0)) begin
         eff_size = rec_size_ff;
         eff_off  = size_offset(rec_size_ff, mode.kind);
      end
      if (!mode.known) begin
         dec_status = STATUS_ERR;
      end else if (!layout_ff && (second_ff <= first_ff)) begin
         dec_status = STATUS_SKIP;
      end else if (layout_ff && (second_ff == '0)) begin
         dec_status = STATUS_SKIP;
      end else begin
         dec_status = STATUS_OK;
      end
      dec_pass  = (dec_status == STATUS_OK);
      tao_start = rec_lsn_ff + ({25'd0, entry_ff} * GAP_PER_ENTRY);
      rebased    = lsn_ff + rebase_amount_ff;
      rebase_neg = rebase_valid_ff && rebased[63];
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = ST_DECODE;
            end
         end
         ST_DECODE: begin
            if (!dec_pass) begin
               state_in = ST_EMIT;
            end else if (layout_ff) begin
               state_in = ST_DIV_COUNT;
            end else begin
               state_in = ST_DIV_LSN;
            end
         end
         ST_DIV_LSN: begin
            if (div_rsp.done) begin
               state_in = ST_REBASE;
            end
         end
         ST_REBASE: begin
            state_in = rebase_neg ? ST_EMIT : ST_DIV_COUNT;
         end
         ST_DIV_COUNT: begin
            if (div_rsp.done) begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      req_ready        = 1'b0;
      rsp_load         = 1'b0;
      div_req.start    = 1'b0;
      div_req.dividend = second_ff - first_ff;
      div_req.divisor  = size_ff;
      unique case (state_ff)
         ST_IDLE: req_ready = 1'b1;
         ST_DECODE: begin
            div_req.start    = dec_pass;
            div_req.dividend = layout_ff ? second_ff : first_ff;
            div_req.divisor  = eff_size;
         end
         ST_REBASE: div_req.start = !rebase_neg;
         ST_EMIT:   rsp_load = !rsp_valid_ff || rsp_ready;
         default: begin
            req_ready = 1'b0;
         end
      endcase
   end

   // datapath
   always_comb begin
      layout_in        = layout_ff;
      entry_in         = entry_ff;
      code_in          = code_ff;
      rec_size_in      = rec_size_ff;
      first_in         = first_ff;
      second_in        = second_ff;
      rec_lsn_in       = rec_lsn_ff;
      size_in          = size_ff;
      off_in           = off_ff;
      kind_in          = kind_ff;
      status_in        = status_ff;
      start_in         = start_ff;
      count_in         = count_ff;
      lsn_in           = lsn_ff;
      rebase_amount_in = rebase_amount_ff;
      rebase_valid_in  = rebase_valid_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               layout_in   = req_layout_kind;
               entry_in    = req_entry_number;
               code_in     = req_mode_code;
               rec_size_in = req_recorded_sector_size;
               first_in    = req_first_offset;
               second_in   = req_second_value;
               rec_lsn_in  = req_recorded_lsn;
            end
         end
         ST_DECODE: begin
            if (entry_ff == '0) begin
               rebase_valid_in  = 1'b0;
               rebase_amount_in = '0;
            end
            size_in   = eff_size;
            off_in    = eff_off;
            kind_in   = mode.kind;
            status_in = dec_status;
            start_in  = tao_start;
         end
         ST_DIV_LSN: begin
            if (div_rsp.done) begin
               lsn_in = div_rsp.quotient - GAP_SECTORS;
            end
         end
         ST_REBASE: begin
            if (!rebase_valid_ff) begin
               rebase_amount_in = '0 - lsn_ff;
               rebase_valid_in  = 1'b1;
               start_in         = '0;
            end else if (rebased[63]) begin
               status_in = STATUS_SKIP;
            end else begin
               start_in = rebased[31:0];
            end
         end
         ST_DIV_COUNT: begin
            if (div_rsp.done) begin
               count_in = div_rsp.quotient[31:0];
            end
         end
         ST_EMIT: begin
            status_in = status_ff;
         end
         default: begin
            status_in = status_ff;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff         <= ST_IDLE;
         rsp_valid_ff     <= 1'b0;
         rebase_valid_ff  <= 1'b0;
         rebase_amount_ff <= '0;
      end else begin
         state_ff         <= state_in;
         rsp_valid_ff     <= rsp_valid_in;
         rebase_valid_ff  <= rebase_valid_in;
         rebase_amount_ff <= rebase_amount_in;
      end
      layout_ff   <= layout_in;
      entry_ff    <= entry_in;
      code_ff     <= code_in;
      rec_size_ff <= rec_size_in;
      first_ff    <= first_in;
      second_ff   <= second_in;
      rec_lsn_ff  <= rec_lsn_in;
      size_ff     <= size_in;
      off_ff      <= off_in;
      kind_ff     <= kind_in;
      status_ff   <= status_in;
      start_ff    <= start_in;
      count_ff    <= count_in;
      lsn_ff      <= lsn_in;
   end

   // load result register; zero every data field of a skip or error
   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_status_ff <= status_ff;
         if (status_ff == STATUS_OK) begin
            rsp_start_ff  <= start_ff;
            rsp_count_ff  <= count_ff;
            rsp_bytes_ff  <= size_ff;
            rsp_off_ff    <= off_ff;
            rsp_kind_ff   <= kind_ff;
            rsp_source_ff <= first_ff;
         end else begin
            rsp_start_ff  <= '0;
            rsp_count_ff  <= '0;
            rsp_bytes_ff  <= '0;
            rsp_off_ff    <= '0;
            rsp_kind_ff   <= '0;
            rsp_source_ff <= '0;
         end
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_status         = rsp_status_ff;
   assign rsp_start_sector   = rsp_start_ff;
   assign rsp_sector_count   = rsp_count_ff;
   assign rsp_sector_bytes   = rsp_bytes_ff;
   assign rsp_payload_offset = rsp_off_ff;
   assign rsp_track_kind     = rsp_kind_ff;
   assign rsp_source_offset  = rsp_source_ff;

   `DITD_ASSERT_IMP(a_div_done_waited, clock, reset, div_rsp.done,
      (state_ff == ST_DIV_LSN) || (state_ff == ST_DIV_COUNT), "divider done outside a wait state")
   `DITD_ASSERT_NXT(a_accept_decodes, clock, reset, req_valid && req_ready,
      state_ff == ST_DECODE, "accepted transaction not decoded")
   `DITD_ASSERT_IMP(a_skip_zeroed, clock, reset, rsp_valid_ff && (rsp_status_ff != STATUS_OK),
      (rsp_start_ff == '0) && (rsp_count_ff == '0) && (rsp_source_ff == '0),
      "skip or error result carries data")
   `DITD_ASSERT_NXT(a_emit_holds, clock, reset,
      (state_ff == ST_EMIT) && rsp_valid_ff && !rsp_ready,
      state_ff == ST_EMIT, "result dropped while output register busy")

endmodule

### tb/ditd_track_checker.sv
`timescale 1ns / 1ps
// Checker that predicts each track entry result and compares it with the rsp_ transaction.
module ditd_track_checker
   import ditd_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_ready,
   input  logic        req_layout_kind,
   input  logic [6:0]  req_entry_number,
   input  logic [31:0] req_mode_code,
   input  logic [15:0] req_recorded_sector_size,
   input  logic [63:0] req_first_offset,
   input  logic [63:0] req_second_value,
   input  logic [31:0] req_recorded_lsn,
   input  logic        rsp_valid,
   input  logic        rsp_ready,
   input  logic [1:0]  rsp_status,
   input  logic [31:0] rsp_start_sector,
   input  logic [31:0] rsp_sector_count,
   input  logic [15:0] rsp_sector_bytes,
   input  logic [4:0]  rsp_payload_offset,
   input  logic [1:0]  rsp_track_kind,
   input  logic [63:0] rsp_source_offset,
   output int          failures,
   output int          outstanding,
   output int          records_seen,
   output int          skips_seen,
   output int          errors_seen
);

   typedef struct packed {
      logic        track_at_once;
      logic [6:0]  entry_number;
      logic [31:0] mode_code;
      logic [15:0] recorded_sector_size;
      logic [63:0] first_offset;
      logic [63:0] second_value;
      logic [31:0] recorded_lsn;
   } track_entry_t;

   typedef struct packed {
      logic [1:0]  status;
      logic [31:0] start_sector;
      logic [31:0] sector_count;
      logic [15:0] sector_bytes;
      logic [4:0]  payload_offset;
      logic [1:0]  track_kind;
      logic [63:0] source_offset;
   } track_record_t;

   track_record_t expected_records[$];
   logic [63:0]   chunk_bias;
   logic          bias_armed;
   int            mismatch_total;
   int            record_total;
   int            skip_total;
   int            error_total;

   initial begin
      failures = 0;
      outstanding = 0;
      records_seen = 0;
      skips_seen = 0;
      errors_seen = 0;
      mismatch_total = 0;
      record_total = 0;
      skip_total = 0;
      error_total = 0;
      chunk_bias = '0;
      bias_armed = 1'b0;
   end

   function automatic track_record_t decode_entry(input track_entry_t e);
      track_record_t r;
      logic          known;
      logic [1:0]    kind;
      logic [15:0]   bytes;
      logic [4:0]    data_off;
      logic [63:0]   addr;
      logic [63:0]   quotient;
      r = '0;
      if (e.entry_number == 7'd0) begin
         bias_armed = 1'b0;
         chunk_bias = '0;
      end
      known = 1'b1;
      kind = KIND_M1;
      bytes = SIZE_2048;
      data_off = OFF_NONE;
      case (e.mode_code)
         MODE_M1_2048: known = 1'b1;
         MODE_M2_2048: kind = KIND_M2;
         MODE_M2_2336_A, MODE_M2_2336_B, MODE_M2_2336_C: begin
            kind = KIND_M2;
            bytes = SIZE_2336;
            data_off = OFF_8;
         end
         MODE_M1_2352: begin
            bytes = SIZE_2352;
            data_off = OFF_16;
         end
         MODE_AUDIO: begin
            kind = KIND_AUDIO;
            bytes = SIZE_2352;
         end
         default: known = 1'b0;
      endcase
      if (!known) begin
         r.status = STATUS_ERR;
         return r;
      end
      if (!e.track_at_once) begin
         if (e.recorded_sector_size != '0) begin
            bytes = e.recorded_sector_size;
            if (bytes == SIZE_2336) begin
               data_off = OFF_8;
            end else if (bytes == SIZE_2352 || bytes == SIZE_2448) begin
               data_off = (kind == KIND_M2) ? OFF_24 : (kind == KIND_M1) ? OFF_16 : OFF_NONE;
            end else begin
               data_off = OFF_NONE;
            end
         end
         if (e.second_value <= e.first_offset) begin
            r.status = STATUS_SKIP;
            return r;
         end
         addr = e.first_offset / {48'd0, bytes} - GAP_SECTORS;
         if (!bias_armed) begin
            chunk_bias = 64'd0 - addr;
            bias_armed = 1'b1;
         end
         addr = addr + chunk_bias;
         if (addr[63]) begin
            r.status = STATUS_SKIP;
            return r;
         end
         quotient = (e.second_value - e.first_offset) / {48'd0, bytes};
         r.start_sector = addr[31:0];
         r.sector_count = quotient[31:0];
      end else begin
         if (e.second_value == '0) begin
            r.status = STATUS_SKIP;
            return r;
         end
         quotient = e.second_value / {48'd0, bytes};
         r.start_sector = e.recorded_lsn + GAP_PER_ENTRY * {25'd0, e.entry_number};
         r.sector_count = quotient[31:0];
      end
      r.status = STATUS_OK;
      r.sector_bytes = bytes;
      r.payload_offset = data_off;
      r.track_kind = kind;
      r.source_offset = e.first_offset;
      return r;
   endfunction

   task automatic compare_field(input string label, input logic [63:0] want,
                                input logic [63:0] got);
      if (want !== got) begin
         $display("%0t: %s mismatch: expected 0x%0h, actual 0x%0h", $time, label, want, got);
         mismatch_total++;
      end
   endtask

   always @(posedge clock) begin : track_monitor
      track_entry_t  entry;
      track_record_t want;
      track_record_t got;
      if (reset) begin
         expected_records.delete();
         chunk_bias = '0;
         bias_armed = 1'b0;
      end else begin
         if (req_valid && req_ready) begin
            entry = {req_layout_kind, req_entry_number, req_mode_code, req_recorded_sector_size,
                     req_first_offset, req_second_value, req_recorded_lsn};
            expected_records.push_back(decode_entry(entry));
         end
         if (rsp_valid && rsp_ready) begin
            got = {rsp_status, rsp_start_sector, rsp_sector_count, rsp_sector_bytes,
                   rsp_payload_offset, rsp_track_kind, rsp_source_offset};
            case (got.status)
               STATUS_OK:   record_total++;
               STATUS_SKIP: skip_total++;
               default:     error_total++;
            endcase
            if (expected_records.size() == 0) begin
               $display("%0t: unexpected result: expected none, actual status %0d start 0x%0h",
                        $time, got.status, got.start_sector);
               mismatch_total++;
            end else begin
               want = expected_records.pop_front();
               compare_field("status", want.status, got.status);
               compare_field("start_sector", want.start_sector, got.start_sector);
               compare_field("sector_count", want.sector_count, got.sector_count);
               compare_field("sector_bytes", want.sector_bytes, got.sector_bytes);
               compare_field("payload_offset", want.payload_offset, got.payload_offset);
               compare_field("track_kind", want.track_kind, got.track_kind);
               compare_field("source_offset", want.source_offset, got.source_offset);
            end
         end
      end
      outstanding <= expected_records.size();
      failures <= mismatch_total;
      records_seen <= record_total;
      skips_seen <= skip_total;
      errors_seen <= error_total;
   end

endmodule

### tb/tb_disc_image_track_entry_decoder.sv
`timescale 1ns / 1ps
// Top of the track entry decoder testbench: clock, reset, stimulus, pacing and verdict.
module tb_disc_image_track_entry_decoder;
   import ditd_pkg::*;

   localparam logic        LAYOUT_DAO = 1'b0;
   localparam logic        LAYOUT_TAO = 1'b1;
   localparam logic [31:0] MODE_UNKNOWN_01  = 32'h01;
   localparam logic [31:0] MODE_UNKNOWN_08  = 32'h08;
   localparam logic [31:0] MODE_UNKNOWN_21  = 32'h21;
   localparam logic [31:0] MODE_UNKNOWN_ALL = 32'hFFFF_FFFF;
   localparam int ITEM_TARGET     = 900;
   localparam int HOLD_OFF_AFTER  = 250;
   localparam int HOLD_OFF_CYCLES = 3000;
   localparam int DRAIN_CYCLES    = 300;
   localparam int CYCLE_LIMIT     = 3000000;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic        req_layout_kind = 1'b0;
   logic [6:0]  req_entry_number = '0;
   logic [31:0] req_mode_code = '0;
   logic [15:0] req_recorded_sector_size = '0;
   logic [63:0] req_first_offset = '0;
   logic [63:0] req_second_value = '0;
   logic [31:0] req_recorded_lsn = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [1:0]  rsp_status;
   logic [31:0] rsp_start_sector;
   logic [31:0] rsp_sector_count;
   logic [15:0] rsp_sector_bytes;
   logic [4:0]  rsp_payload_offset;
   logic [1:0]  rsp_track_kind;
   logic [63:0] rsp_source_offset;
   int          failures;
   int          outstanding;
   int          records_seen;
   int          skips_seen;
   int          errors_seen;
   int          offered_items = 0;
   bit          no_idle = 1'b0;

   always #5 clock = ~clock;

   disc_image_track_entry_decoder u_dut (.*);

   ditd_track_checker u_checker (.*);

   function automatic int pick_gap();
      int roll;
      if (no_idle) return 0;
      roll = $urandom_range(0, 99);
      if (roll < 55) return 0;
      if (roll < 90) return $urandom_range(1, 3);
      if (roll < 98) return $urandom_range(4, 20);
      return $urandom_range(40, 300);
   endfunction

   function automatic logic [31:0] pick_mode();
      case ($urandom_range(0, 19))
         0, 1, 2:    return MODE_M1_2048;
         3, 4:       return MODE_M2_2048;
         5, 6:       return MODE_M2_2336_A;
         7:          return MODE_M2_2336_B;
         8:          return MODE_M2_2336_C;
         9, 10, 11:  return MODE_M1_2352;
         12, 13, 14: return MODE_AUDIO;
         15, 16:     return MODE_M1_2352;
         17:         return MODE_UNKNOWN_08;
         default:    return $urandom;
      endcase
   endfunction

   function automatic logic [15:0] pick_sector_size();
      case ($urandom_range(0, 19))
         0:       return SIZE_2048;
         1:       return SIZE_2336;
         2:       return SIZE_2352;
         3:       return SIZE_2448;
         4:       return 16'($urandom);
         default: return '0;
      endcase
   endfunction

   task automatic offer_entry(input logic layout, input logic [6:0] number,
                              input logic [31:0] mode, input logic [15:0] rec_size,
                              input logic [63:0] first, input logic [63:0] second,
                              input logic [31:0] lsn);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_layout_kind <= layout;
      req_entry_number <= number;
      req_mode_code <= mode;
      req_recorded_sector_size <= rec_size;
      req_first_offset <= first;
      req_second_value <= second;
      req_recorded_lsn <= lsn;
      do @(posedge clock); while (!req_ready);
      offered_items++;
   endtask

   task automatic send_dao_chunk();
      int          count;
      logic [63:0] cursor;
      logic [63:0] unit;
      logic [63:0] first;
      logic [63:0] second;
      logic [15:0] rec_size;
      logic [6:0]  number;
      count = ($urandom_range(0, 19) == 0) ? $urandom_range(40, 99) : $urandom_range(1, 12);
      cursor = 64'($urandom_range(0, 400000)) * 64'd2352;
      for (int i = 0; i < count; i++) begin
         rec_size = pick_sector_size();
         unit = (rec_size != '0) ? 64'(rec_size) : 64'd2352;
         first = cursor + 64'($urandom_range(0, 300)) * unit + 64'($urandom_range(0, 2447));
         if ($urandom_range(0, 9) == 0) first = cursor - 64'($urandom_range(0, 2000)) * unit;
         second = first;
         if ($urandom_range(0, 9) != 0)
            second = first + 64'($urandom_range(1, 4000)) * unit + 64'($urandom_range(0, 100));
         if ($urandom_range(0, 29) == 0) second = {$urandom, $urandom};
         number = ($urandom_range(0, 29) == 0) ? 7'($urandom_range(0, 127)) : 7'(i);
         offer_entry(LAYOUT_DAO, number, pick_mode(), rec_size, first, second, $urandom);
         cursor = second;
      end
   endtask

   task automatic send_tao_chunk();
      int          count;
      logic [63:0] cursor;
      logic [63:0] length;
      logic [31:0] lsn;
      logic [6:0]  number;
      count = ($urandom_range(0, 19) == 0) ? $urandom_range(40, 99) : $urandom_range(1, 12);
      cursor = 64'($urandom_range(0, 400000)) * 64'd2352;
      lsn = ($urandom_range(0, 3) == 0) ? 32'hFFFF_FFFF - 32'($urandom_range(0, 20000))
                                        : 32'($urandom_range(0, 300000));
      for (int i = 0; i < count; i++) begin
         length = '0;
         if ($urandom_range(0, 9) != 0)
            length = 64'($urandom_range(1, 4000)) * 64'd2352 + 64'($urandom_range(0, 2351));
         if ($urandom_range(0, 29) == 0) length = {$urandom, $urandom};
         number = ($urandom_range(0, 29) == 0) ? 7'($urandom_range(0, 127)) : 7'(i);
         offer_entry(LAYOUT_TAO, number, pick_mode(), 16'($urandom), cursor, length, lsn);
         cursor = cursor + length;
         lsn = lsn + 32'($urandom_range(0, 100000));
      end
   endtask

   task automatic send_noise_entry();
      offer_entry(1'($urandom), 7'($urandom_range(0, 127)),
                  ($urandom_range(0, 1) == 0) ? pick_mode() : $urandom, 16'($urandom),
                  {$urandom, $urandom}, {$urandom, $urandom}, $urandom);
   endtask

   initial begin : rsp_pacing
      int stall;
      bit held;
      held = 1'b0;
      @(posedge clock);
      forever begin
         if (!held && offered_items >= HOLD_OFF_AFTER) begin
            held = 1'b1;
            rsp_ready <= 1'b0;
            repeat (HOLD_OFF_CYCLES) @(posedge clock);
         end else begin
            stall = pick_gap();
            if (stall > 0) begin
               rsp_ready <= 1'b0;
               repeat (stall) @(posedge clock);
            end
            rsp_ready <= 1'b1;
            @(posedge clock);
         end
      end
   end

   initial begin : watchdog
      int unsigned cycle_count;
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("Timeout after %0d cycles with %0d results outstanding", cycle_count, outstanding);
      $display("** disc_image_track_entry_decoder: FAILED **");
      $finish;
   end

   initial begin : stimulus
      int roll;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // rebase on the first kept entry, then a later one, then one below the base
      offer_entry(LAYOUT_DAO, 7'd0, MODE_M1_2048, '0, 64'd2048000, 64'd2088960, '0);
      offer_entry(LAYOUT_DAO, 7'd1, MODE_M2_2048, '0, 64'd2457600, 64'd2467940, '0);
      offer_entry(LAYOUT_DAO, 7'd2, MODE_M2_2336_A, '0, 64'd1168000, 64'd1400000, '0);
      offer_entry(LAYOUT_DAO, 7'd3, MODE_M2_2336_B, SIZE_2448, 64'd4896000, 64'd4996000,
                  32'hFFFF_FFFF);
      offer_entry(LAYOUT_DAO, 7'd4, MODE_M2_2336_C, SIZE_2352, 64'd5000000, 64'd5100000, '0);
      offer_entry(LAYOUT_DAO, 7'd5, MODE_M1_2352, SIZE_2352, 64'd5200000, 64'd5300000, '0);
      offer_entry(LAYOUT_DAO, 7'd6, MODE_AUDIO, SIZE_2448, 64'd5400000, 64'd5500000, '0);
      offer_entry(LAYOUT_DAO, 7'd7, MODE_M1_2352, SIZE_2048, 64'd5600000, 64'd5700000, '0);
      offer_entry(LAYOUT_DAO, 7'd8, MODE_M1_2048, SIZE_2336, 64'd5800000, 64'd5900000, '0);
      offer_entry(LAYOUT_DAO, 7'd9, MODE_AUDIO, 16'hFFFF, 64'hFFFF_FFFF_FFFF_FFF0,
                  64'hFFFF_FFFF_FFFF_FFFF, '0);
      offer_entry(LAYOUT_DAO, 7'd10, MODE_M1_2048, 16'd1, '0, 64'hFFFF_FFFF_FFFF_FFFF, '0);
      offer_entry(LAYOUT_DAO, 7'd11, MODE_M1_2048, '0, 64'd6000000, 64'd6000000, '0);
      offer_entry(LAYOUT_DAO, 7'd12, MODE_M1_2048, '0, 64'd6000000, 64'd5000000, '0);
      offer_entry(LAYOUT_DAO, 7'd13, MODE_UNKNOWN_01, '0, 64'd1000, 64'd9000, '0);
      // unknown mode at entry zero still restarts the chunk
      offer_entry(LAYOUT_DAO, 7'd0, MODE_UNKNOWN_ALL, 16'hFFFF, 64'd100, 64'd50, '0);
      offer_entry(LAYOUT_DAO, 7'd1, MODE_M1_2048, '0, 64'd9000000, 64'd9000000, '0);
      offer_entry(LAYOUT_DAO, 7'd2, MODE_M1_2352, '0, 64'd9000000, 64'd9100000, '0);
      offer_entry(LAYOUT_DAO, 7'd3, MODE_UNKNOWN_08, '0, 64'd1000, 64'd9000, '0);
      offer_entry(LAYOUT_TAO, 7'd0, MODE_AUDIO, '0, 64'd352800, '0, 32'd1000);
      offer_entry(LAYOUT_TAO, 7'd98, MODE_M1_2352, 16'hFFFF, 64'd0, 64'd23520,
                  32'hFFFF_FFFF);
      offer_entry(LAYOUT_TAO, 7'd127, MODE_M2_2336_C, '0, 64'hFFFF_FFFF_FFFF_FFFF,
                  64'hFFFF_FFFF_FFFF_FFFF, 32'hFFFF_FF00);
      offer_entry(LAYOUT_TAO, 7'd1, MODE_UNKNOWN_21, '0, 64'd0, 64'd4096, '0);
      offer_entry(LAYOUT_TAO, 7'd2, MODE_M2_2048, '0, 64'd4096, 64'd4095, '0);

      while (offered_items < ITEM_TARGET) begin
         no_idle = (offered_items >= 500 && offered_items < 600);
         roll = $urandom_range(0, 99);
         if (roll < 45) begin
            send_dao_chunk();
         end else if (roll < 88) begin
            send_tao_chunk();
         end else begin
            send_noise_entry();
         end
      end
      no_idle = 1'b0;
      req_valid <= 1'b0;
      do @(posedge clock); while (outstanding != 0);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Run covered %0d entries in disc-at-once and track-at-once chunks plus noise,",
               offered_items);
      $display("with a %0d-cycle receiver hold-off: %0d records, %0d skips, %0d bad modes.",
               HOLD_OFF_CYCLES, records_seen, skips_seen, errors_seen);
      if (failures == 0) begin
         $display("** disc_image_track_entry_decoder: PASSED **");
      end else begin
         $display("%0d mismatches", failures);
         $display("** disc_image_track_entry_decoder: FAILED **");
      end
      $finish;
   end

endmodule
